### design/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int SLOTS_DEF      = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int HASH_BITS      = 32;
  localparam int SIZE_BITS      = 9;
  localparam int OUT_VAL_BITS   = 32;
  localparam int COUNT_BITS     = 32;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_GONE  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        set_dropped;
    logic [31:0] collision_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, start modulo
    logic mod_step;   // one restoring-division step
    logic probe_rd;   // issue memory read at current index
    logic probe_eval; // evaluate read data, advance index
    logic commit;     // apply write and emit result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic probe_stop;
  } dp_sts_t;

endpackage

### design/open_address_hash_table_top.sv
// ----------------------------------------------------------------------------
// open_address_hash_table_top
// Open-addressing key/value table with caller-supplied hash.
// ----------------------------------------------------------------------------
// channel  | ports                        | handshake
// input    | start, busy, in_item         | accepted when start && !busy
// result   | out_valid, out_item          | one-cycle strobe, no back-pressure
// config   | cfg_we, cfg_wdata            | written when cfg_we
//
// After the accepting edge an item runs the bit-serial hash modulo, then a
// memory read and an evaluate per probed slot, then a commit; the result
// strobes in the commit cycle. busy drops after commit, so a new item is not
// taken until the last one is through; the receiver never stalls.
// Slot states reset via per-slot valid flops, so no clearing pass. Reset is
// synchronous, active low.
// ----------------------------------------------------------------------------
module open_address_hash_table_top #(
  parameter int SLOTS      = oaht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  oaht_pkg::in_item_t  in_item,
  output logic                out_valid,
  output oaht_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata
);

  oaht_pkg::dp_cmd_t cmd;
  oaht_pkg::dp_sts_t sts;

  oaht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd), .done(out_valid)
  );

  oaht_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_in(in_item), .cmd(cmd), .sts(sts), .result(out_item)
  );

endmodule

### design/oaht_datapath.sv
// ----------------------------------------------------------------------------
// oaht_datapath
// Hash modulo unit, probe index stepping, slot memories and result logic.
// ----------------------------------------------------------------------------
module oaht_datapath #(
  parameter int SLOTS      = oaht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata,
  input  oaht_pkg::in_item_t  item_in,
  input  oaht_pkg::dp_cmd_t   cmd,
  output oaht_pkg::dp_sts_t   sts,
  output oaht_pkg::out_item_t result
);

  localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SZ_BITS  = $clog2(SLOTS + 1);
  localparam int HB       = oaht_pkg::HASH_BITS;
  localparam int RB       = (SZ_BITS > oaht_pkg::SIZE_BITS) ? SZ_BITS : oaht_pkg::SIZE_BITS;

  logic [oaht_pkg::SIZE_BITS-1:0] table_size_r;
  logic [SZ_BITS-1:0]   size_r;
  logic [1:0]           op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [HB-1:0]        quo_r;
  logic [RB:0]          rem_r;
  logic [$clog2(HB+1)-1:0] mcnt_r;
  logic [IDX_BITS-1:0]  idx_r;
  logic [SZ_BITS-1:0]   left_r;
  logic                 first_r;
  logic                 found_r, free_r;
  logic                 fstep_nz_r, frstep_nz_r;
  logic [IDX_BITS-1:0]  found_idx_r, free_idx_r;
  logic [1:0]           st_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [oaht_pkg::COUNT_BITS-1:0] coll_r;
  logic [SLOTS-1:0]     used_v_r;

  logic [1:0]            status_mem [SLOTS];
  logic [KEY_BITS-1:0]   key_mem    [SLOTS];
  logic [VALUE_BITS-1:0] val_mem    [SLOTS];

  logic [SZ_BITS-1:0] act_size;
  logic [RB:0]        rem_sh;
  logic [RB:0]        rem_sub;
  logic [SZ_BITS:0]   idx_sum;
  logic [SZ_BITS-1:0] left_dec;
  logic               hit_key, stop_now;
  logic [1:0]         st_eff;
  logic               coll_inc;

  always_comb begin
    if (table_size_r == '0 || 32'(table_size_r) > SLOTS) act_size = SZ_BITS'(SLOTS);
    else act_size = SZ_BITS'(table_size_r);
  end

  assign rem_sh  = {rem_r[RB-1:0], quo_r[HB-1]};
  assign rem_sub = rem_sh - (RB+1)'(size_r);
  assign sts.mod_done = (mcnt_r == '0);

  assign st_eff   = used_v_r[idx_r] ? st_q : oaht_pkg::ST_EMPTY;
  assign hit_key  = (st_eff == oaht_pkg::ST_USED) && (key_q == key_r);
  assign left_dec = left_r - 1'b1;
  assign stop_now = (st_eff == oaht_pkg::ST_EMPTY) || hit_key || (left_dec == '0);
  assign sts.probe_stop = stop_now;
  assign idx_sum  = (SZ_BITS+1)'(idx_r) + (SZ_BITS+1)'(left_dec);

  // a set counts unless it landed on the first probed slot; a dropped set counts
  assign coll_inc = (op_r == oaht_pkg::OP_SET) &&
                    (found_r ? fstep_nz_r : (free_r ? frstep_nz_r : 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= oaht_pkg::SIZE_RESET;
      coll_r       <= '0;
      mcnt_r       <= '0;
      used_v_r     <= '0;
    end else begin
      if (cfg_we) table_size_r <= cfg_wdata;
      if (cmd.load) begin
        mcnt_r <= ($clog2(HB+1))'(HB);
      end else if (cmd.mod_step && mcnt_r != '0) begin
        mcnt_r <= mcnt_r - 1'b1;
      end
      if (cmd.commit) begin
        if (coll_inc) coll_r <= coll_r + 1'b1;
        if (op_r == oaht_pkg::OP_SET && !found_r && free_r) used_v_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= item_in.operation;
      key_r <= KEY_BITS'(item_in.key);
      val_r <= VALUE_BITS'(item_in.value);
      quo_r <= item_in.key_hash;
      rem_r <= '0;
      size_r <= act_size;
      found_r <= 1'b0;
      free_r  <= 1'b0;
      first_r <= 1'b1;
    end else if (cmd.mod_step && mcnt_r != '0) begin
      quo_r <= {quo_r[HB-2:0], 1'b0};
      rem_r <= rem_sub[RB] ? rem_sh : rem_sub;
      if (mcnt_r == 1) begin
        idx_r  <= IDX_BITS'(rem_sub[RB] ? rem_sh : rem_sub);
        left_r <= size_r;
      end
    end else if (cmd.probe_eval) begin
      first_r <= 1'b0;
      if (hit_key) begin
        found_r <= 1'b1;
        found_idx_r <= idx_r;
        fstep_nz_r  <= !first_r;
      end else if (st_eff != oaht_pkg::ST_USED && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= idx_r;
        frstep_nz_r <= !first_r;
      end
      left_r <= left_dec;
      idx_r  <= (idx_sum >= (SZ_BITS+1)'(size_r)) ?
                IDX_BITS'(idx_sum - (SZ_BITS+1)'(size_r)) : IDX_BITS'(idx_sum);
    end
  end

  // slot memories: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.probe_rd) begin
      st_q  <= status_mem[idx_r];
      key_q <= key_mem[idx_r];
      val_q <= val_mem[idx_r];
    end
    if (cmd.commit) begin
      if (op_r == oaht_pkg::OP_SET) begin
        if (found_r) begin
          val_mem[found_idx_r] <= val_r;
        end else if (free_r) begin
          status_mem[free_idx_r] <= oaht_pkg::ST_USED;
          key_mem[free_idx_r]    <= key_r;
          val_mem[free_idx_r]    <= val_r;
        end
      end else if (op_r == oaht_pkg::OP_REMOVE && found_r) begin
        status_mem[found_idx_r] <= oaht_pkg::ST_GONE;
      end
    end
  end

  // found slot's value is still in val_q when the probe stops on a hit
  always_comb begin
    result = '0;
    result.collision_count = coll_r + oaht_pkg::COUNT_BITS'(coll_inc);
    case (op_r)
      oaht_pkg::OP_LOOKUP: begin
        result.hit = found_r;
        if (found_r) result.read_value = oaht_pkg::OUT_VAL_BITS'(val_q);
      end
      oaht_pkg::OP_REMOVE: result.hit = found_r;
      oaht_pkg::OP_SET:    result.set_dropped = !found_r && !free_r;
      default: ;
    endcase
  end

endmodule

### design/oaht_ctrl.sv
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer: modulo, probe read/evaluate loop, commit.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  oaht_pkg::dp_sts_t sts,
  output oaht_pkg::dp_cmd_t cmd,
  output logic              done
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_RD   = 5'b00100,
    S_EVAL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd  = '0;
    done = 1'b0;
    case (state_r)
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.probe_eval = 1'b1;
        state_nxt = sts.probe_stop ? S_DONE : S_RD;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_done_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r) == S_EVAL)
    else $error("commit without probe");
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_MOD)
    else $error("accepted item not loaded");

endmodule
